// File: rtl/core/triangle_coverage_depth_test_macros.svh
// Assertion macros used by the checker of this block
`ifndef TRIANGLE_COVERAGE_DEPTH_TEST_MACROS_SVH
`define TRIANGLE_COVERAGE_DEPTH_TEST_MACROS_SVH

// Check a same-cycle implication
`define TCDT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle
`define TCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/tcdt_pkg.sv
package tcdt_pkg;
	localparam int NUM_TRI     = 2;
	localparam int TRI_W       = 1;
	localparam int VTX_PER_TRI = 3;
	localparam int NUM_ENTRIES = NUM_TRI * VTX_PER_TRI;
	localparam int ADDR_W      = 3;
	localparam int CW          = 12;
	localparam int FW          = 8;
	localparam int DW          = CW + FW;
	localparam int PIX_W       = 10;
	localparam int VIDX_W      = 2;
	localparam int ENTRY_W     = 3 * CW;
	localparam int DIFF_W      = CW + 2;
	localparam int PW          = 2 * DIFF_W;
	localparam int PROD_W      = PW + DIFF_W;
	localparam int NUM_W       = PROD_W + 1;
	localparam int DVD_W       = NUM_W + FW;
	localparam int QW          = DW + 2;
	localparam int QCNT_W      = 5;
	localparam int MSTEP_W     = 4;
	localparam int MSTEP_LAST  = 12;
	localparam int DEPTH_MAX   = 2 ** (DW - 1) - 1;
	localparam int DEPTH_MIN   = -(2 ** (DW - 1));

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic [VIDX_W-1:0] VIDX_NONE = 2'd3;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [PW-1:0]    den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [QW:0]   quo;
	} div_rsp_t;
endpackage

// File: rtl/core/triangle_coverage_depth_test.sv
// Triangle coverage and depth test. Pulse start with busy low to issue a request:
// op=0 writes one vertex (x,y,z) of slot tri_index at vertex_index with busy
// staying low (vertex_index 3 is dropped); op=1 tests pixel (pixel_x, pixel_y)
// against both stored triangles in order. A pixel request holds busy while, for
// each triangle, it reads 3 vertices from the vertex memory with its registered
// read, runs 13 steps of one shared multiplier and one check, then, for a
// covering triangle only, a 22-step restoring divider and its result, then one
// advance; busy also stays high through the result state.
// The result appears on covered, winner and depth for exactly one cycle with
// done high, and the receiver cannot stall it. Depth is signed with 8 fraction
// bits. The vertex memory reads as all zero after reset.
module triangle_coverage_depth_test import tcdt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [TRI_W-1:0]     tri_index,
	input  logic [VIDX_W-1:0]    vertex_index,
	input  logic signed [CW-1:0] vert_x,
	input  logic signed [CW-1:0] vert_y,
	input  logic signed [CW-1:0] vert_z,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	output logic                 done,
	output logic                 covered,
	output logic                 winner,
	output logic signed [DW-1:0] depth
);
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic               query;
	div_req_t           dreq;
	div_rsp_t           drsp;

	// Decode accepted requests; busy interlocks writes against a running query
	assign wr_en   = start && !busy && (op == OP_LOAD) && (vertex_index != VIDX_NONE);
	assign wr_addr = ADDR_W'(tri_index) * ADDR_W'(VTX_PER_TRI) + ADDR_W'(vertex_index);
	assign query   = start && !busy && (op == OP_QUERY);

	tcdt_vstore u_vstore (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({vert_x, vert_y, vert_z}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tcdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	tcdt_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.query   (query),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.dreq    (dreq),
		.drsp    (drsp),
		.busy    (busy),
		.done    (done),
		.covered (covered),
		.winner  (winner),
		.depth   (depth)
	);
endmodule

// File: rtl/core/tcdt_vstore.sv
module tcdt_vstore import tcdt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_data
);
	logic [ENTRY_W-1:0]     mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] valid_q;
	logic [ENTRY_W-1:0]     rd_q;
	logic                   rd_vld_q;

	// Write and read the vertex array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Track written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;
endmodule

// File: rtl/core/tcdt_div.sv
module tcdt_div import tcdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [DVD_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dsh_q;
	logic [QW-1:0]     quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              neg_q;
	logic              done_q;
	logic [NUM_W-1:0]  num_mag;
	logic [PW-1:0]     den_mag;

	// Take magnitudes of the operands
	always_comb begin
		num_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
		den_mag = req.den[PW-1] ? PW'(-req.den) : PW'(req.den);
	end

	// Restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= QCNT_W'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {num_mag, {FW{1'b0}}};
			dsh_q <= DVD_W'(den_mag) << (QW - 1);
			neg_q <= req.num[NUM_W-1] ^ req.den[PW-1];
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

// File: rtl/core/tcdt_eval.sv
module tcdt_eval import tcdt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  query,
	input  logic [PIX_W-1:0]      pixel_x,
	input  logic [PIX_W-1:0]      pixel_y,
	output logic [ADDR_W-1:0]     rd_addr,
	input  logic [ENTRY_W-1:0]    rd_data,
	output div_req_t              dreq,
	input  div_rsp_t              drsp,
	output logic                  busy,
	output logic                  done,
	output logic                  covered,
	output logic                  winner,
	output logic signed [DW-1:0]  depth
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_CHK  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_NEXT = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [PIX_W-1:0]          px_q, py_q;
	logic [TRI_W-1:0]          tri_q;
	logic [1:0]                rcnt_q;
	logic [1:0]                vsel;
	logic signed [CW-1:0]      vx_q [3];
	logic signed [CW-1:0]      vy_q [3];
	logic signed [CW-1:0]      vz_q [3];
	logic [MSTEP_W-1:0]        mstep_q;
	logic [MSTEP_W-1:0]        tag_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PW-1:0]      area_q, wa_q, wb_q, u_q, v_q;
	logic signed [NUM_W-1:0]   num_q;
	logic signed [DW-1:0]      best_q;
	logic                      hit_q;
	logic [TRI_W-1:0]          win_q;
	logic signed [DIFF_W-1:0]  ax, ay, az, bx, by, bz, cx, cy, cz, xx, yy;
	logic signed [PW-1:0]      ma;
	logic signed [DIFF_W-1:0]  mb;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PW-1:0]      p_lo;
	logic signed [PW+1:0]      wc;
	logic                      cov;
	logic signed [DW+3:0]      dsum;
	logic signed [DW-1:0]      dsat;

	// Widen coordinates for the edge arithmetic
	always_comb begin
		ax = DIFF_W'(vx_q[0]);
		ay = DIFF_W'(vy_q[0]);
		az = DIFF_W'(vz_q[0]);
		bx = DIFF_W'(vx_q[1]);
		by = DIFF_W'(vy_q[1]);
		bz = DIFF_W'(vz_q[1]);
		cx = DIFF_W'(vx_q[2]);
		cy = DIFF_W'(vy_q[2]);
		cz = DIFF_W'(vz_q[2]);
		xx = $signed({{(DIFF_W-PIX_W){1'b0}}, px_q});
		yy = $signed({{(DIFF_W-PIX_W){1'b0}}, py_q});
	end

	// Select multiplier operands for each product step
	always_comb begin
		ma = '0;
		mb = '0;
		case (mstep_q)
			4'd0: begin ma = PW'(by - cy); mb = ax - cx; end
			4'd1: begin ma = PW'(cx - bx); mb = ay - cy; end
			4'd2: begin ma = PW'(by - cy); mb = xx - cx; end
			4'd3: begin ma = PW'(cx - bx); mb = yy - cy; end
			4'd4: begin ma = PW'(cy - ay); mb = xx - cx; end
			4'd5: begin ma = PW'(ax - cx); mb = yy - cy; end
			4'd6: begin ma = PW'(xx - ax); mb = cy - ay; end
			4'd7: begin ma = PW'(cx - ax); mb = yy - ay; end
			4'd8: begin ma = PW'(bx - ax); mb = yy - ay; end
			4'd9: begin ma = PW'(by - ay); mb = xx - ax; end
			4'd10: begin ma = u_q; mb = bz - az; end
			4'd11: begin ma = v_q; mb = cz - az; end
			default: begin ma = '0; mb = '0; end
		endcase
		prod = ma * mb;
		p_lo = prod_s1[PW-1:0];
	end

	// Coverage test on the three weights
	always_comb begin
		wc  = (PW+2)'(area_q) - (PW+2)'(wa_q) - (PW+2)'(wb_q);
		cov = 1'b0;
		if (area_q > 0) begin
			cov = !(wa_q < 0 || wb_q < 0 || wc < 0);
		end else if (area_q < 0) begin
			cov = !(wa_q > 0 || wb_q > 0 || wc > 0);
		end
	end

	// Form and saturate the interpolated depth
	always_comb begin
		dsum = $signed({(DW+4-FW)'(vz_q[0]), {FW{1'b0}}}) + (DW+4)'(drsp.quo);
		if (dsum > DEPTH_MAX) begin
			dsat = DW'(DEPTH_MAX);
		end else if (dsum < DEPTH_MIN) begin
			dsat = DW'(DEPTH_MIN);
		end else begin
			dsat = dsum[DW-1:0];
		end
	end

	assign vsel    = (rcnt_q == 2'd3) ? 2'd0 : rcnt_q;
	assign rd_addr = ADDR_W'(tri_q) * ADDR_W'(VTX_PER_TRI) + ADDR_W'(vsel);

	// Sequence one query over all triangles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tri_q   <= '0;
			rcnt_q  <= '0;
			mstep_q <= '0;
			hit_q   <= 1'b0;
			win_q   <= '0;
			best_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (query) begin
						tri_q   <= '0;
						rcnt_q  <= '0;
						hit_q   <= 1'b0;
						win_q   <= '0;
						best_q  <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					rcnt_q <= rcnt_q + 1'b1;
					if (rcnt_q == 2'd3) begin
						mstep_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == MSTEP_W'(MSTEP_LAST)) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= cov ? S_DIV : S_NEXT;
				end
				S_DIV: begin
					if (drsp.done) begin
						if (dsat > best_q) begin
							best_q <= dsat;
							win_q  <= tri_q;
							hit_q  <= 1'b1;
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (tri_q == TRI_W'(NUM_TRI - 1)) begin
						state_q <= S_OUT;
					end else begin
						tri_q   <= tri_q + 1'b1;
						rcnt_q  <= '0;
						state_q <= S_READ;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture pixel and vertices, register products and accumulate
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && query) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (state_q == S_READ && rcnt_q != 2'd0) begin
			vx_q[rcnt_q - 2'd1] <= rd_data[3*CW-1:2*CW];
			vy_q[rcnt_q - 2'd1] <= rd_data[2*CW-1:CW];
			vz_q[rcnt_q - 2'd1] <= rd_data[CW-1:0];
		end
		if (state_q == S_MUL) begin
			prod_s1 <= prod;
			tag_s1  <= mstep_q;
			if (mstep_q != '0) begin
				case (tag_s1)
					4'd0: area_q <= p_lo;
					4'd1: area_q <= area_q + p_lo;
					4'd2: wa_q <= p_lo;
					4'd3: wa_q <= wa_q + p_lo;
					4'd4: wb_q <= p_lo;
					4'd5: wb_q <= wb_q + p_lo;
					4'd6: u_q <= p_lo;
					4'd7: u_q <= u_q - p_lo;
					4'd8: v_q <= p_lo;
					4'd9: v_q <= v_q - p_lo;
					4'd10: num_q <= NUM_W'(prod_s1);
					4'd11: num_q <= num_q + NUM_W'(prod_s1);
					default: num_q <= num_q;
				endcase
			end
		end
	end

	assign dreq.start = (state_q == S_CHK) && cov;
	assign dreq.num   = num_q;
	assign dreq.den   = area_q;

	assign busy    = (state_q != S_IDLE);
	assign done    = (state_q == S_OUT);
	assign covered = hit_q;
	assign winner  = win_q;
	assign depth   = best_q;
endmodule

// File: rtl/core/tcdt_checker.sv
`include "triangle_coverage_depth_test_macros.svh"

module tcdt_checker import tcdt_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 op,
	input logic                 done,
	input logic                 covered,
	input logic                 winner,
	input logic signed [DW-1:0] depth
);
	// Results only come out of a running query
	`TCDT_ASSERT_NOW(a_done_busy, done, busy, "result outside a query")
	// A pixel request starts a query
	`TCDT_ASSERT_NEXT(a_query_busy, start && !busy && op == OP_QUERY, busy, "query not started")
	// A load request leaves the block free
	`TCDT_ASSERT_NEXT(a_load_free, start && !busy && op == OP_LOAD, !busy, "load blocked")
	// Background result carries no winner and no depth
	`TCDT_ASSERT_NOW(a_bg_zero, done && !covered, winner == 1'b0 && depth == '0, "bad background")
	// A covered result has a positive depth
	`TCDT_ASSERT_NOW(a_cov_pos, done && covered, depth > 0, "nonpositive winning depth")
endmodule

bind triangle_coverage_depth_test tcdt_checker u_tcdt_checker (.*);

// File: tb/triangle_coverage_depth_test_tb.sv
`timescale 1ns / 100ps

module triangle_coverage_depth_test_tb;
	import tcdt_pkg::*;

	typedef struct {
		logic                 covered;
		logic                 winner;
		logic signed [DW-1:0] depth;
	} pixel_result_t;

	// Pixel predictor with its own copy of the vertex table
	class pixel_scoreboard;
		longint vx[NUM_ENTRIES];
		longint vy[NUM_ENTRIES];
		longint vz[NUM_ENTRIES];
		pixel_result_t pending[$];
		int errors;

		function void clear_table();
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				vx[i] = 0;
				vy[i] = 0;
				vz[i] = 0;
			end
		endfunction

		// Test one triangle against the pixel; returns 1 and its depth when covered
		function bit shade_triangle(int t, longint x, longint y, output longint d);
			longint ax, ay, az, bx, by, bz, cx, cy, cz;
			longint area, wa, wb, wc, den, u, v, num, hi, lo;
			ax = vx[t*3];   ay = vy[t*3];   az = vz[t*3];
			bx = vx[t*3+1]; by = vy[t*3+1]; bz = vz[t*3+1];
			cx = vx[t*3+2]; cy = vy[t*3+2]; cz = vz[t*3+2];
			d = 0;
			area = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
			if (area == 0)
				return 0;
			wa = (by - cy) * (x - cx) + (cx - bx) * (y - cy);
			wb = (cy - ay) * (x - cx) + (ax - cx) * (y - cy);
			wc = area - wa - wb;
			if (area > 0 && (wa < 0 || wb < 0 || wc < 0))
				return 0;
			if (area < 0 && (wa > 0 || wb > 0 || wc > 0))
				return 0;
			den = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
			if (den == 0)
				return 0;
			u = (x - ax) * (cy - ay) - (cx - ax) * (y - ay);
			v = (bx - ax) * (y - ay) - (by - ay) * (x - ax);
			num = (u * (bz - az) + v * (cz - az)) * (longint'(1) << FW);
			d = az * (longint'(1) << FW) + num / den;
			hi = DEPTH_MAX;
			lo = DEPTH_MIN;
			if (d > hi) d = hi;
			if (d < lo) d = lo;
			return 1;
		endfunction

		// Note an accepted request
		function void note_request(logic o, logic [TRI_W-1:0] t, logic [VIDX_W-1:0] vi,
				logic signed [CW-1:0] x, logic signed [CW-1:0] y,
				logic signed [CW-1:0] z, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
			pixel_result_t r;
			longint best, d;
			if (o == OP_LOAD) begin
				if (vi != VIDX_NONE && t < NUM_TRI) begin
					vx[t*3+vi] = x;
					vy[t*3+vi] = y;
					vz[t*3+vi] = z;
				end
				return;
			end
			best = 0;
			r.covered = 0;
			r.winner = 0;
			for (int i = 0; i < NUM_TRI; i++) begin
				if (shade_triangle(i, longint'(px), longint'(py), d) && d > best) begin
					best = d;
					r.covered = 1;
					r.winner = i[0];
				end
			end
			r.depth = r.covered ? DW'(best) : '0;
			pending.push_back(r);
		endfunction

		// Compare a strobed result with the oldest expectation
		function void check_result(logic c, logic w, logic signed [DW-1:0] dp);
			pixel_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result covered=%0d winner=%0d depth=%0d", c, w, dp);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (c !== e.covered) begin
				$error("covered: expected %0d, got %0d", e.covered, c);
				errors++;
			end
			if (w !== e.winner) begin
				$error("winner: expected %0d, got %0d", e.winner, w);
				errors++;
			end
			if (dp !== e.depth) begin
				$error("depth: expected %0d, got %0d", e.depth, dp);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 op;
	logic [TRI_W-1:0]     tri_index;
	logic [VIDX_W-1:0]    vertex_index;
	logic signed [CW-1:0] vert_x;
	logic signed [CW-1:0] vert_y;
	logic signed [CW-1:0] vert_z;
	logic [PIX_W-1:0]     pixel_x;
	logic [PIX_W-1:0]     pixel_y;
	logic                 done;
	logic                 covered;
	logic                 winner;
	logic signed [DW-1:0] depth;

	pixel_scoreboard sb;
	int idle_pct;
	int quiet_cycles;

	triangle_coverage_depth_test uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.tri_index(tri_index), .vertex_index(vertex_index), .vert_x(vert_x),
		.vert_y(vert_y), .vert_z(vert_z), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.done(done), .covered(covered), .winner(winner), .depth(depth)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Score accepted requests and results, and watch for a stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(op, tri_index, vertex_index, vert_x, vert_y, vert_z,
					pixel_x, pixel_y);
			if (done)
				sb.check_result(covered, winner, depth);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Issue one request and hold it until accepted; drop start only while idling
	task automatic send_request(logic o, logic [TRI_W-1:0] t, logic [VIDX_W-1:0] vi,
			logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic signed [CW-1:0] z,
			logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		tri_index <= t;
		vertex_index <= vi;
		vert_x <= x;
		vert_y <= y;
		vert_z <= z;
		pixel_x <= px;
		pixel_y <= py;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic load_vertex(int t, int vi, int x, int y, int z);
		send_request(OP_LOAD, TRI_W'(t), VIDX_W'(vi), CW'(x), CW'(y), CW'(z),
			PIX_W'($urandom), PIX_W'($urandom));
	endtask

	task automatic query_pixel(int px, int py);
		send_request(OP_QUERY, TRI_W'($urandom), VIDX_W'($urandom), CW'($urandom),
			CW'($urandom), CW'($urandom), PIX_W'(px), PIX_W'(py));
	endtask

	// Load a triangle that straddles the pixel region, with random depths
	task automatic load_random_triangle(int t);
		int cx, cy, r;
		cx = $urandom_range(1023, 0);
		cy = $urandom_range(1023, 0);
		r = ($urandom_range(3, 0) == 0) ? $urandom_range(2047, 1) : $urandom_range(64, 1);
		for (int v = 0; v < 3; v++)
			load_vertex(t, v,
				$signed(cx + $urandom_range(2 * r, 0) - r) > 2047 ? 2047 :
					cx + $urandom_range(2 * r, 0) - r,
				cy + $urandom_range(2 * r, 0) - r - ((cy + r > 2047) ? r : 0),
				$urandom_range(4095, 0) - 2048);
	endtask

	initial begin
		sb = new();
		sb.clear_table();
		idle_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_LOAD;
		tri_index = '0;
		vertex_index = '0;
		vert_x = '0;
		vert_y = '0;
		vert_z = '0;
		pixel_x = '0;
		pixel_y = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Degenerate table after reset
		query_pixel(0, 0);
		query_pixel(1023, 1023);
		// Full-range triangle with extreme depths, and a vertex index three drop
		load_vertex(0, 0, -2048, -2048, 2047);
		load_vertex(0, 1, 2047, -2048, -2048);
		load_vertex(0, 2, -2048, 2047, 2047);
		load_vertex(0, VIDX_NONE, 0, 0, -2048);
		query_pixel(0, 0);
		query_pixel(1023, 1023);
		query_pixel(1023, 0);
		// Clockwise triangle in slot 1, nearer, overlapping slot 0
		load_vertex(1, 0, 0, 0, 2047);
		load_vertex(1, 1, 0, 1023, 2047);
		load_vertex(1, 2, 1023, 0, 2047);
		query_pixel(10, 10);
		query_pixel(1023, 1023);
		query_pixel(0, 1023);
		// Negative depth never wins; a line-shaped triangle never covers
		load_vertex(1, 0, 0, 0, -5);
		load_vertex(1, 1, 100, 0, -5);
		load_vertex(1, 2, 0, 100, -5);
		query_pixel(5, 5);
		load_vertex(0, 0, 0, 0, 100);
		load_vertex(0, 1, 10, 10, 100);
		load_vertex(0, 2, 20, 20, 100);
		query_pixel(10, 10);

		// Random phases: sender idles lightly, then heavily, then never
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 11 : ((ph == 1) ? 62 : 0);
			for (int n = 0; n < 440; n++) begin
				case ($urandom_range(9, 0))
					0: load_random_triangle($urandom_range(1, 0));
					1: load_vertex($urandom, $urandom, $urandom, $urandom, $urandom);
					default: query_pixel($urandom_range(1023, 0), $urandom_range(1023, 0));
				endcase
			end
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
